// ----- hdl/bech32_string_encoder_assert.svh -----
// Assertion macros shared by the encoder's checking code.
`ifndef BECH32_STRING_ENCODER_ASSERT_SVH
`define BECH32_STRING_ENCODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define B32E_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define B32E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/b32enc_pkg.sv -----
// Types, codes, tables and the polymod step shared by the encoder modules.
package b32enc_pkg;

   localparam int CHECK_SYMBOLS = 6;

   localparam logic [1:0] KIND_PREFIX = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_CHAR  = 3'd1;
   localparam logic [2:0] ERR_LONG  = 3'd2;
   localparam logic [2:0] ERR_SHORT = 3'd3;
   localparam logic [2:0] ERR_ORDER = 3'd4;

   localparam logic [2:0] PM_HOLD  = 3'd0;
   localparam logic [2:0] PM_INIT  = 3'd1;
   localparam logic [2:0] PM_STEP  = 3'd2;
   localparam logic [2:0] PM_STEPX = 3'd3;
   localparam logic [2:0] PM_SHIFT = 3'd4;

   localparam logic [6:0] CHAR_FIRST = 7'h21;
   localparam logic [6:0] CHAR_DEL   = 7'h7F;
   localparam logic [6:0] CHAR_UP_A  = 7'h41;
   localparam logic [6:0] CHAR_UP_Z  = 7'h5A;
   localparam logic [6:0] CHAR_CASE  = 7'h20;
   localparam logic [6:0] SEP_CHAR   = 7'h31;

   localparam logic [29:0] CONST_BECH32  = 30'h1;
   localparam logic [29:0] CONST_BECH32M = 30'h2bc830a3;

   localparam logic [29:0] PM_GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   localparam logic [6:0] ALPHABET [32] = '{
      7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
      7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
      7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
      7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] char_in;
      logic [7:0] data_bits;
      logic [3:0] bit_count;
      logic       use_bech32m;
   } req_type;

   typedef struct packed {
      logic       has_char;
      logic [6:0] char_out;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] val;
      logic       sel;
   } pm_ctrl_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic clear;
   } rg_ctrl_type;

   typedef struct packed {
      logic [3:0] left;
      logic [2:0] fill;
      logic [4:0] full_sym;
      logic [4:0] pad_sym;
   } rg_stat_type;

   function automatic logic [29:0] pm_step(input logic [29:0] c);
      logic [4:0]  top;
      logic [29:0] r;
      top = c[29:25];
      r   = {c[24:0], 5'd0};
      for (int i = 0; i < 5; i++) begin
         if (top[i]) r = r ^ PM_GEN[i];
      end
      return r;
   endfunction

endpackage

// ----- hdl/b32enc_polymod.sv -----
// Checksum register with a one-step-per-cycle polymod unit.
module b32enc_polymod import b32enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  pm_ctrl_type ctrl,
   output logic [29:0] check_out
);

   logic [29:0] check_ff;
   logic [29:0] check_in;

   always_comb begin
      unique case (ctrl.op)
         PM_INIT:  check_in = CONST_BECH32;
         PM_STEP:  check_in = pm_step(check_ff) ^ {25'd0, ctrl.val};
         PM_STEPX: check_in = pm_step(check_ff) ^ (ctrl.sel ? CONST_BECH32M : CONST_BECH32);
         PM_SHIFT: check_in = {check_ff[24:0], 5'd0};
         default:  check_in = check_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= CONST_BECH32;
      end else begin
         check_ff <= check_in;
      end
   end

   assign check_out = check_ff;

endmodule

// ----- hdl/b32enc_hrp_mem.sv -----
// Buffer of the prefix characters' low five bits with a registered read port.
module b32enc_hrp_mem #(
   parameter int DEPTH = 83,
   parameter int IDX_W = 7
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [4:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [4:0]       rd_data
);

   logic [4:0] mem [DEPTH];
   logic [4:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/b32enc_regroup.sv -----
// Bit-serial regrouping of data chunks into 5-bit symbols.
module b32enc_regroup import b32enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rg_ctrl_type ctrl,
   input  logic [7:0]  load_data,
   input  logic [3:0]  load_count,
   output rg_stat_type stat
);

   logic [7:0] data_sh_ff, data_sh_in;
   logic [3:0] left_ff, left_in;
   logic [2:0] fill_ff, fill_in;
   logic [3:0] sym_ff, sym_in;

   always_comb begin
      data_sh_in = data_sh_ff;
      left_in    = left_ff;
      fill_in    = fill_ff;
      sym_in     = sym_ff;
      priority if (ctrl.load) begin
         // left-align the valid bits; bits above the count fall off
         data_sh_in = 8'(load_data << (4'd8 - load_count));
         left_in    = load_count;
      end else if (ctrl.advance) begin
         data_sh_in = {data_sh_ff[6:0], 1'b0};
         left_in    = left_ff - 4'd1;
         if (fill_ff == 3'd4) begin
            fill_in = 3'd0;
            sym_in  = 4'd0;
         end else begin
            fill_in = fill_ff + 3'd1;
            sym_in  = {sym_ff[2:0], data_sh_ff[7]};
         end
      end else if (ctrl.clear) begin
         fill_in = 3'd0;
         sym_in  = 4'd0;
      end else begin
         data_sh_in = data_sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 4'd0;
         fill_ff <= 3'd0;
         sym_ff  <= 4'd0;
      end else begin
         left_ff <= left_in;
         fill_ff <= fill_in;
         sym_ff  <= sym_in;
      end
      data_sh_ff <= data_sh_in;
   end

   assign stat.left     = left_ff;
   assign stat.fill     = fill_ff;
   assign stat.full_sym = {sym_ff, data_sh_ff[7]};
   assign stat.pad_sym  = 5'({1'b0, sym_ff} << (3'd5 - fill_ff));

endmodule

// ----- hdl/bech32_string_encoder.sv -----
// Bech32/Bech32m string encoder: bit-serial regrouping, at most one polymod step per cycle.
// A prefix character is checked and echoed; a data chunk is regrouped bit by bit.
// The first data or finish item also replays the prefix: zero separator step, stored low bits.
// Finish: pad symbol if bits remain, six polymod steps, six checksum characters.
// Requests stall until the previous item is done and the sequencer is idle again;
// output stalls hold the sequencer. Sync reset clears phase, length and fill; checksum to one.
`include "bech32_string_encoder_assert.svh"

module bech32_string_encoder import b32enc_pkg::*; #(
   parameter int PREFIX_MAX = 83,
   parameter int PREFIX_MIN = 1
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int LEN_W = $clog2(PREFIX_MAX + 1);
   localparam int IDX_W = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_REPLAY = 3'd2;
   localparam logic [2:0] S_SEP    = 3'd3;
   localparam logic [2:0] S_DATA   = 3'd4;
   localparam logic [2:0] S_PAD    = 3'd5;
   localparam logic [2:0] S_CKEXT  = 3'd6;
   localparam logic [2:0] S_CKOUT  = 3'd7;

   logic [2:0]       state_ff, state_in;
   req_type          item_ff, item_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] rep_ff, rep_in;
   logic             phase_ff, phase_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             out_free;
   logic             emit;
   rsp_type          emit_rsp;
   logic [3:0]       cnt_clamp;
   logic             is_upper;
   logic [6:0]       lower_char;
   logic [4:0]       high_sym;
   logic [LEN_W-1:0] rep_next;
   logic [4:0]       more_sum;

   pm_ctrl_type      pm_ctrl;
   logic [29:0]      check;
   rg_ctrl_type      rg_ctrl;
   rg_stat_type      rg_stat;
   logic             mem_wr_en;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [4:0]       mem_rd_data;

   b32enc_polymod u_polymod (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pm_ctrl),
      .check_out (check)
   );

   b32enc_regroup u_regroup (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rg_ctrl),
      .load_data  (req_data.data_bits),
      .load_count (cnt_clamp),
      .stat       (rg_stat)
   );

   b32enc_hrp_mem #(
      .DEPTH (PREFIX_MAX),
      .IDX_W (IDX_W)
   ) u_hrp_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (item_ff.char_in[4:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_clamp = (req_data.bit_count > 4'd8) ? 4'd8 : req_data.bit_count;

   assign is_upper   = (item_ff.char_in >= CHAR_UP_A) && (item_ff.char_in <= CHAR_UP_Z);
   assign lower_char = is_upper ? (item_ff.char_in | CHAR_CASE) : item_ff.char_in;
   assign high_sym   = {3'd0, item_ff.char_in[6:5]} | {4'd0, is_upper};
   assign rep_next   = LEN_W'(rep_ff + 1'b1);
   assign more_sum   = {2'd0, rg_stat.fill} + {1'b0, rg_stat.left};

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      len_in      = len_ff;
      rep_in      = rep_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      emit        = 1'b0;
      emit_rsp    = '0;
      pm_ctrl     = '{op: PM_HOLD, val: 5'd0, sel: item_ff.use_bech32m};
      rg_ctrl     = '0;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in      = req_data;
               rg_ctrl.load = (req_data.kind == KIND_DATA);
               state_in     = S_DECODE;
            end
         end

         S_DECODE: begin
            priority if ((item_ff.kind != KIND_PREFIX && item_ff.kind != KIND_DATA &&
                          item_ff.kind != KIND_FINISH) ||
                         (item_ff.kind == KIND_PREFIX && phase_ff)) begin
               emit_rsp = '{has_char: 1'b0, char_out: 7'd0, error_code: ERR_ORDER,
                            last: 1'b1};
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (item_ff.kind == KIND_PREFIX) begin
               if (len_ff >= LEN_W'(PREFIX_MAX)) begin
                  emit_rsp = '{has_char: 1'b0, char_out: 7'd0, error_code: ERR_LONG,
                               last: 1'b1};
               end else if (item_ff.char_in < CHAR_FIRST || item_ff.char_in >= CHAR_DEL) begin
                  emit_rsp = '{has_char: 1'b0, char_out: 7'd0, error_code: ERR_CHAR,
                               last: 1'b1};
               end else begin
                  emit_rsp = '{has_char: 1'b1, char_out: lower_char, error_code: ERR_OK,
                               last: 1'b1};
               end
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (emit_rsp.error_code == ERR_OK) begin
                     // first expansion pass folds in as the character arrives
                     pm_ctrl.op  = PM_STEP;
                     pm_ctrl.val = high_sym;
                     mem_wr_en   = 1'b1;
                     len_in      = LEN_W'(len_ff + 1'b1);
                  end
               end
            end else if (!phase_ff) begin
               if (32'(len_ff) < 32'(PREFIX_MIN)) begin
                  emit_rsp = '{has_char: 1'b0, char_out: 7'd0, error_code: ERR_SHORT,
                               last: 1'b1};
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  // zero separator symbol, then replay the buffered low bits
                  pm_ctrl.op  = PM_STEP;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  rep_in      = '0;
                  state_in    = S_REPLAY;
               end
            end else if (item_ff.kind == KIND_DATA) begin
               state_in = S_DATA;
            end else begin
               state_in = S_PAD;
            end
         end

         S_REPLAY: begin
            pm_ctrl.op  = PM_STEP;
            pm_ctrl.val = mem_rd_data;
            if (rep_next < len_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rep_next[IDX_W-1:0];
               rep_in      = rep_next;
            end else begin
               state_in = S_SEP;
            end
         end

         S_SEP: begin
            emit_rsp = '{has_char: 1'b1, char_out: SEP_CHAR, error_code: ERR_OK,
                         last: (item_ff.kind == KIND_DATA) && (more_sum < 5'd5)};
            if (out_free) begin
               emit     = 1'b1;
               phase_in = 1'b1;
               state_in = (item_ff.kind == KIND_DATA) ? S_DATA : S_PAD;
            end
         end

         S_DATA: begin
            emit_rsp = '{has_char: 1'b1, char_out: ALPHABET[rg_stat.full_sym],
                         error_code: ERR_OK, last: (rg_stat.left <= 4'd5)};
            if (rg_stat.left == 4'd0) begin
               state_in = S_IDLE;
            end else if (rg_stat.fill == 3'd4) begin
               // this bit completes a symbol: hold until the output slot frees
               if (out_free) begin
                  emit            = 1'b1;
                  rg_ctrl.advance = 1'b1;
                  pm_ctrl.op      = PM_STEP;
                  pm_ctrl.val     = rg_stat.full_sym;
               end
            end else begin
               rg_ctrl.advance = 1'b1;
            end
         end

         S_PAD: begin
            emit_rsp = '{has_char: 1'b1, char_out: ALPHABET[rg_stat.pad_sym],
                         error_code: ERR_OK, last: 1'b0};
            cnt_in   = 3'd0;
            if (rg_stat.fill == 3'd0) begin
               state_in = S_CKEXT;
            end else if (out_free) begin
               emit          = 1'b1;
               pm_ctrl.op    = PM_STEP;
               pm_ctrl.val   = rg_stat.pad_sym;
               rg_ctrl.clear = 1'b1;
               state_in      = S_CKEXT;
            end
         end

         S_CKEXT: begin
            if (cnt_ff == 3'(CHECK_SYMBOLS - 1)) begin
               pm_ctrl.op = PM_STEPX;
               cnt_in     = 3'd0;
               state_in   = S_CKOUT;
            end else begin
               pm_ctrl.op = PM_STEP;
               cnt_in     = cnt_ff + 3'd1;
            end
         end

         S_CKOUT: begin
            emit_rsp = '{has_char: 1'b1, char_out: ALPHABET[check[29:25]],
                         error_code: ERR_OK, last: (cnt_ff == 3'(CHECK_SYMBOLS - 1))};
            if (out_free) begin
               emit = 1'b1;
               if (cnt_ff == 3'(CHECK_SYMBOLS - 1)) begin
                  // string done: back to the reset state
                  pm_ctrl.op = PM_INIT;
                  len_in     = '0;
                  phase_in   = 1'b0;
                  cnt_in     = 3'd0;
                  state_in   = S_IDLE;
               end else begin
                  pm_ctrl.op = PM_SHIFT;
                  cnt_in     = cnt_ff + 3'd1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rep_ff       <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rep_ff       <= rep_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `B32E_ASSERT_NEXT(a_accept_decode, req_valid && !req_stall, state_ff == S_DECODE, "accepted transaction did not reach decode")
   `B32E_ASSERT_SAME(a_error_last, rsp_valid_ff && rsp_ff.error_code != ERR_OK, rsp_ff.last && !rsp_ff.has_char, "error transaction must be last and carry no character")
   `B32E_ASSERT_SAME(a_replay_range, state_ff == S_REPLAY, rep_ff < len_ff, "prefix replay ran past the stored length")
   `B32E_ASSERT_SAME(a_len_bound, 1'b1, len_ff <= LEN_W'(PREFIX_MAX), "prefix length above maximum")

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the Bech32/Bech32m string encoder: directed rows, then random strings.
`timescale 1ns / 100ps

module testbench import b32enc_pkg::*; ();

   localparam logic [1:0]  KIND_BAD      = 2'd3;
   localparam int          HRP_MAX       = 83;
   localparam int          HRP_MIN       = 1;
   localparam int          ITEM_GOAL     = 280;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          DRAIN_CYCLES  = 100;
   localparam logic [6:0]  SEPARATOR     = 7'h31;
   localparam logic [6:0]  CASE_BIT      = 7'h20;
   localparam logic [29:0] BECH32M_XOR   = 30'h2bc830a3;
   localparam logic [29:0] BECH32_XOR    = 30'h1;
   localparam logic [29:0] GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };
   localparam string CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } step_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // encoder state as the predictor tracks it
   logic [4:0]  hrp_low [HRP_MAX];
   int          hrp_len;
   logic [29:0] chk;
   int          acc;
   int          fill;
   bit          data_phase;

   rsp_type awaited_chars[$];
   rsp_type batch[$];
   step_row_type directed_rows[$];

   int fail_count     = 0;
   int items_sent     = 0;
   int rsp_checked    = 0;
   int err_rsp        = 0;
   int strings_closed = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;
   int stall_cycle    = 0;
   int stall_mode     = 0;

   bech32_string_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [29:0] polymod_shift(logic [29:0] c);
      logic [29:0] r;
      r = {c[24:0], 5'd0};
      for (int i = 0; i < 5; i++)
         if (c[25 + i]) r = r ^ GEN[i];
      return r;
   endfunction

   function automatic void clear_encoder();
      hrp_len    = 0;
      chk        = 30'd1;
      acc        = 0;
      fill       = 0;
      data_phase = 1'b0;
   endfunction

   function automatic void emit(logic [6:0] ch, logic [2:0] err);
      rsp_type r;
      r.has_char   = (ch != 7'd0);
      r.char_out   = ch;
      r.error_code = err;
      r.last       = 1'b0;
      batch.push_back(r);
   endfunction

   function automatic void emit_symbol(logic [4:0] v);
      chk = polymod_shift(chk) ^ {25'd0, v};
      emit(7'(CHARSET[v]), ERR_OK);
   endfunction

   // Work out the results one transaction causes and advance the tracked state.
   function automatic void encode_step(req_type it);
      logic [6:0]  c;
      logic [1:0]  hi;
      logic [29:0] v;
      bit          upper;
      int          cnt;
      batch.delete();
      c     = it.char_in;
      upper = (c >= 7'h41 && c <= 7'h5A);
      if (it.kind == KIND_BAD) begin
         emit(7'd0, ERR_ORDER);
      end else if (it.kind == KIND_PREFIX) begin
         if (data_phase) emit(7'd0, ERR_ORDER);
         else if (hrp_len >= HRP_MAX) emit(7'd0, ERR_LONG);
         else if (c < 7'h21 || c == 7'h7F) emit(7'd0, ERR_CHAR);
         else begin
            hi  = c[6:5] | {1'b0, upper};
            chk = polymod_shift(chk) ^ {28'd0, hi};
            hrp_low[hrp_len] = c[4:0];
            hrp_len++;
            emit(upper ? (c | CASE_BIT) : c, ERR_OK);
         end
      end else if (!data_phase && hrp_len < HRP_MIN) begin
         emit(7'd0, ERR_SHORT);
      end else begin
         if (!data_phase) begin
            // zero separator step, then replay the low five bits of the prefix
            chk = polymod_shift(chk);
            for (int i = 0; i < hrp_len; i++)
               chk = polymod_shift(chk) ^ {25'd0, hrp_low[i]};
            emit(SEPARATOR, ERR_OK);
            data_phase = 1'b1;
         end
         if (it.kind == KIND_DATA) begin
            cnt = (it.bit_count > 4'd8) ? 8 : int'(it.bit_count);
            if (cnt > 0) begin
               acc  = ((acc << cnt) | (int'(it.data_bits) & ((1 << cnt) - 1))) & 'hFFF;
               fill = fill + cnt;
            end
            while (fill >= 5) begin
               fill = fill - 5;
               emit_symbol(5'(acc >> fill));
            end
            acc = acc & ((1 << fill) - 1);
         end else begin
            if (fill > 0) emit_symbol(5'(acc << (5 - fill)));
            v = chk;
            repeat (CHECK_SYMBOLS) v = polymod_shift(v);
            v = v ^ (it.use_bech32m ? BECH32M_XOR : BECH32_XOR);
            for (int i = CHECK_SYMBOLS - 1; i >= 0; i--)
               emit_symbol(5'(v >> (5 * i)));
            clear_encoder();
            strings_closed++;
         end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
   endfunction

   function automatic step_row_type dir_row(logic [1:0] k, logic [6:0] c, logic [7:0] d,
         logic [3:0] n, logic m, logic [2:0] err = ERR_OK, logic [6:0] echo = 7'd0);
      step_row_type r;
      r.item  = {k, c, d, n, m};
      r.fixed = (err != ERR_OK) || (echo != 7'd0);
      r.want  = {echo != 7'd0, echo, err, 1'b1};
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Present one transaction; predict at the falling edge before the accepting edge.
   task automatic send_item(req_type it, bit fixed = 1'b0, rsp_type want = '0);
      bit taken;
      req_data  <= it;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            encode_step(it);
            if (fixed) awaited_chars.push_back(want);
            else foreach (batch[i]) awaited_chars.push_back(batch[i]);
            items_sent++;
         end
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = 1;
            2: gap = $urandom_range(2, 6);
            default: gap = $urandom_range(7, 24);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off the sender until every awaited result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (awaited_chars.size() != 0);
   endtask

   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 120 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_cycle % 9) < 4);
      endcase
   end

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_checked++;
         if (rsp_data.error_code != ERR_OK) err_rsp++;
         if (awaited_chars.size() == 0) begin
            report("unexpected result", int'(rsp_data), 0);
         end else begin
            want = awaited_chars.pop_front();
            if (rsp_data.has_char !== want.has_char)
               report("has_char", rsp_data.has_char, want.has_char);
            if (rsp_data.char_out !== want.char_out)
               report("char_out", rsp_data.char_out, want.char_out);
            if (rsp_data.error_code !== want.error_code)
               report("error_code", rsp_data.error_code, want.error_code);
            if (rsp_data.last !== want.last)
               report("last", rsp_data.last, want.last);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      req_type it;
      int      hrp_n;
      int      chunks;
      clear_encoder();
      // empty prefix, out-of-order kind, illegal characters
      directed_rows.push_back(dir_row(KIND_DATA,   7'h41, 8'hFF, 4'd8,  1'b0, ERR_SHORT));
      directed_rows.push_back(dir_row(KIND_FINISH, 7'h7F, 8'h00, 4'd15, 1'b1, ERR_SHORT));
      directed_rows.push_back(dir_row(KIND_BAD,    7'h61, 8'h00, 4'd0,  1'b0, ERR_ORDER));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h00, 8'h00, 4'd0,  1'b0, ERR_CHAR));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h20, 8'h00, 4'd0,  1'b0, ERR_CHAR));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h7F, 8'hFF, 4'd15, 1'b1, ERR_CHAR));
      // legal prefix characters, upper case folded
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h42, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h62));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h41, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h61));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h5A, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h7A));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h21, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h21));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h7E, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h7E));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h40, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h40));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h5B, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h5B));
      // close with an empty chunk, then prefix and bad kind in data phase
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'hFF, 4'd0, 1'b0));
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h61, 8'h00, 4'd0, 1'b0, ERR_ORDER));
      directed_rows.push_back(dir_row(KIND_BAD,    7'h7F, 8'hFF, 4'd15, 1'b1, ERR_ORDER));
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'hFF, 4'd8,  1'b0));
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'h5A, 4'd15, 1'b0));
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'hFE, 4'd1,  1'b0));
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'h00, 4'd0,  1'b0));
      directed_rows.push_back(dir_row(KIND_FINISH, 7'h00, 8'h00, 4'd0,  1'b1));
      // finish closes the prefix directly, Bech32 constant
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h7A, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h7A));
      directed_rows.push_back(dir_row(KIND_FINISH, 7'h00, 8'h00, 4'd0, 1'b0));
      // one full symbol, no padding on finish
      directed_rows.push_back(dir_row(KIND_PREFIX, 7'h30, 8'h00, 4'd0, 1'b0, ERR_OK, 7'h30));
      directed_rows.push_back(dir_row(KIND_DATA,   7'h00, 8'h1F, 4'd5, 1'b0));
      directed_rows.push_back(dir_row(KIND_FINISH, 7'h00, 8'h00, 4'd0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
         pace();
      end
      drain();

      // random strings; the second one overruns the prefix limit
      for (int s = 0; items_sent < ITEM_GOAL; s++) begin
         if (s == 1) hrp_n = HRP_MAX + 2;
         else if ($urandom_range(0, 24) == 0) hrp_n = $urandom_range(40, HRP_MAX + 1);
         else hrp_n = $urandom_range(0, 8);
         for (int k = 0; k < hrp_n; k++) begin
            it      = 22'($urandom);
            it.kind = KIND_PREFIX;
            if (s == 1 || $urandom_range(0, 19) != 0) it.char_in = 7'($urandom_range(33, 126));
            send_item(it);
            pace();
         end
         chunks = $urandom_range(0, 12);
         for (int k = 0; k < chunks; k++) begin
            it      = 22'($urandom);
            it.kind = KIND_DATA;
            if ($urandom_range(0, 7) != 0) it.bit_count = 4'($urandom_range(1, 8));
            send_item(it);
            pace();
            // noise: any kind, any field
            if ($urandom_range(0, 14) == 0) begin
               send_item(22'($urandom));
               pace();
            end
         end
         if ($urandom_range(0, 9) != 0) begin
            it      = 22'($urandom);
            it.kind = KIND_FINISH;
            send_item(it);
            pace();
         end
         if ($urandom_range(0, 7) == 0) drain();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items, %0d finished strings, %0d results compared",
               items_sent, strings_closed, rsp_checked);
      $display("of those results %0d carried an error code", err_rsp);
      if (fail_count == 0 && awaited_chars.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
